// ===== rtl/core/cje_pkg.sv =====
// Shared types, constants and helper functions for the cubic Julia escape-time block.
package cje_pkg;

   // Field widths fixed by the interface.
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 10;
   localparam int CSR_IDX_W = 2;

   // Default fixed-point fraction width and register reset values.
   localparam int DEFAULT_FRAC_BITS = 28;
   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 10'd100;

   // Width of the signed intermediates used for shifts, sums and clamps.
   localparam int WIDE_W = 68;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_C_REAL   = 2'd0,
      CSR_C_IMAG   = 2'd1,
      CSR_MAX_ITER = 2'd2
   } csr_index_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_TEST,
      ST_CUBE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_start;
      logic square;
      logic load_ab;
      logic cube;
      logic update;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic done;
   } status_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
      lo = -WIDE_W'(64'sh0000_0000_8000_0000);
      if (v > hi) begin
         sat32 = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (v < lo) begin
         sat32 = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat32 = v[VALUE_W-1:0];
      end
   endfunction

   // Clamp a wide signed value to the signed 33-bit range.
   function automatic logic signed [VALUE_W:0] sat33(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sh0000_0000_FFFF_FFFF);
      lo = -WIDE_W'(64'sh0000_0001_0000_0000);
      if (v > hi) begin
         sat33 = {1'b0, {VALUE_W{1'b1}}};
      end else if (v < lo) begin
         sat33 = {1'b1, {VALUE_W{1'b0}}};
      end else begin
         sat33 = v[VALUE_W:0];
      end
   endfunction

endpackage

// ===== rtl/core/cje_datapath.sv =====
// Datapath: z registers, multipliers, escape test, iteration counter and result register.
module cje_datapath #(
   parameter int FRAC_BITS = cje_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                  clock,
   input  cje_pkg::cmd_type                      cmd,
   output cje_pkg::status_type                   status,
   input  logic signed [cje_pkg::VALUE_W-1:0]    start_real,
   input  logic signed [cje_pkg::VALUE_W-1:0]    start_imag,
   input  logic signed [cje_pkg::VALUE_W-1:0]    c_real,
   input  logic signed [cje_pkg::VALUE_W-1:0]    c_imag,
   input  logic [cje_pkg::COUNT_W-1:0]           max_iterations,
   output logic [cje_pkg::COUNT_W-1:0]           iteration_count
);

   localparam int VW = cje_pkg::VALUE_W;
   localparam int WW = cje_pkg::WIDE_W;
   localparam int PW = 2 * VW;
   // The escape threshold 4 << (2*FRAC_BITS) only fits the squared magnitude when small enough.
   localparam bit ESC_NEVER = (2 * FRAC_BITS + 2 >= PW);
   localparam int ESC_SHIFT = ESC_NEVER ? PW - 1 : 2 * FRAC_BITS + 2;

   logic signed [VW-1:0]   zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PW-1:0]   p0_ff, p0_in, p1_ff, p1_in;
   logic signed [VW:0]     a_ff, a_in, b_ff, b_in;
   logic signed [PW-1:0]   q0_ff, q0_in, q1_ff, q1_in;
   logic [cje_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [cje_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [PW-1:0]          mag;
   logic                   in_disk;
   logic signed [VW-1:0]   rr, ii;
   logic signed [WW-1:0]   rr_w, ii_w, a_w, b_w;
   logic signed [PW:0]     prod0, prod1;
   logic signed [WW-1:0]   nr_w, ni_w;

   // Squares of z; a square is never negative, so it doubles as |z|^2 terms.
   assign p0_in = cmd.square ? zr_ff * zr_ff : p0_ff;
   assign p1_in = cmd.square ? zi_ff * zi_ff : p1_ff;

   // Escape test against 4 in fixed point.
   assign mag     = p0_ff + p1_ff;
   assign in_disk = ESC_NEVER || ((mag >> ESC_SHIFT) == '0);
   assign status.done = (count_ff >= max_iterations) || !in_disk;

   // Scaled squares and the cubic cross terms a = rr - 3*ii, b = 3*rr - ii.
   assign rr = cje_pkg::sat32($signed({{(WW-PW){p0_ff[PW-1]}}, p0_ff}) >>> FRAC_BITS);
   assign ii = cje_pkg::sat32($signed({{(WW-PW){p1_ff[PW-1]}}, p1_ff}) >>> FRAC_BITS);
   assign rr_w = $signed({{(WW-VW){rr[VW-1]}}, rr});
   assign ii_w = $signed({{(WW-VW){ii[VW-1]}}, ii});
   assign a_w  = rr_w - ((ii_w <<< 1) + ii_w);
   assign b_w  = ((rr_w <<< 1) + rr_w) - ii_w;
   assign a_in = cmd.load_ab ? cje_pkg::sat33(a_w) : a_ff;
   assign b_in = cmd.load_ab ? cje_pkg::sat33(b_w) : b_ff;

   // Cube products, kept as 64-bit two's complement.
   assign prod0 = zr_ff * a_ff;
   assign prod1 = zi_ff * b_ff;
   assign q0_in = cmd.cube ? prod0[PW-1:0] : q0_ff;
   assign q1_in = cmd.cube ? prod1[PW-1:0] : q1_ff;

   // New z: floor shift, add c, clamp.
   assign nr_w = ($signed({{(WW-PW){q0_ff[PW-1]}}, q0_ff}) >>> FRAC_BITS)
               + $signed({{(WW-VW){c_real[VW-1]}}, c_real});
   assign ni_w = ($signed({{(WW-PW){q1_ff[PW-1]}}, q1_ff}) >>> FRAC_BITS)
               + $signed({{(WW-VW){c_imag[VW-1]}}, c_imag});

   always_comb begin
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      count_in = count_ff;
      if (cmd.load_start) begin
         zr_in    = start_real;
         zi_in    = start_imag;
         count_in = '0;
      end else if (cmd.update) begin
         zr_in    = cje_pkg::sat32(nr_w);
         zi_in    = cje_pkg::sat32(ni_w);
         count_in = count_ff + 1'b1;
      end
   end

   // Result register holds the count until it is taken.
   assign rsp_count_in    = cmd.load_rsp ? count_ff : rsp_count_ff;
   assign iteration_count = rsp_count_ff;

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      q0_ff        <= q0_in;
      q1_ff        <= q1_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

// ===== rtl/core/cje_controller.sv =====
// Controller: sequences the iteration steps and owns both channel handshakes.
module cje_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cje_pkg::status_type status,
   output cje_pkg::cmd_type    cmd
);

   cje_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   // The result register can take a new beat when empty or when being drained.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cje_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cje_pkg::ST_SQUARE;
            end
         end
         cje_pkg::ST_SQUARE: begin
            state_in = cje_pkg::ST_TEST;
         end
         cje_pkg::ST_TEST: begin
            state_in = status.done ? cje_pkg::ST_FINISH : cje_pkg::ST_CUBE;
         end
         cje_pkg::ST_CUBE: begin
            state_in = cje_pkg::ST_UPDATE;
         end
         cje_pkg::ST_UPDATE: begin
            state_in = cje_pkg::ST_SQUARE;
         end
         cje_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = cje_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cje_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         cje_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_start = req_valid;
         end
         cje_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
         end
         cje_pkg::ST_TEST: begin
            cmd.load_ab = !status.done;
         end
         cje_pkg::ST_CUBE: begin
            cmd.cube = 1'b1;
         end
         cje_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         cje_pkg::ST_FINISH: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result beat valid flag.
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cje_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/cubic_julia_escape_time.sv =====
// Top level of the cubic Julia escape-time block: configuration registers and unit wiring.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   req_start_real, req_start_imag (Q4.28)
//   rsp_      out        rsp_valid / rsp_ready   rsp_iteration_count
//   csr_      in         csr_write_enable        csr_index, csr_write_data
//
// After a point is accepted, each iteration squares z, tests the magnitude and the limit,
// forms the cube terms and updates z; a final square and test precede the result load.
// Each iteration squares z on one pair of multipliers and forms the cube terms on a second
// pair, with a register after each. The next beat is taken the cycle after a result is
// loaded; no new point is taken while one is in progress, and the load step stalls while
// the previous result is still held. Reset is synchronous and clears the controller,
// the result flag and the c registers, and sets the limit to its reset value.
module cubic_julia_escape_time #(
   parameter int FRAC_BITS = cje_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [cje_pkg::VALUE_W-1:0]   req_start_real,
   input  logic signed [cje_pkg::VALUE_W-1:0]   req_start_imag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cje_pkg::COUNT_W-1:0]          rsp_iteration_count,
   input  logic                                 csr_write_enable,
   input  logic [cje_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cje_pkg::VALUE_W-1:0]          csr_write_data
);

   logic signed [cje_pkg::VALUE_W-1:0] c_real_ff, c_real_in;
   logic signed [cje_pkg::VALUE_W-1:0] c_imag_ff, c_imag_in;
   logic [cje_pkg::COUNT_W-1:0]        max_iter_ff, max_iter_in;

   cje_pkg::cmd_type    cmd;
   cje_pkg::status_type status;

   // Register writes; unknown indexes are dropped.
   always_comb begin
      c_real_in   = c_real_ff;
      c_imag_in   = c_imag_ff;
      max_iter_in = max_iter_ff;
      if (csr_write_enable) begin
         case (cje_pkg::csr_index_type'(csr_index))
            cje_pkg::CSR_C_REAL: begin
               c_real_in = csr_write_data;
            end
            cje_pkg::CSR_C_IMAG: begin
               c_imag_in = csr_write_data;
            end
            cje_pkg::CSR_MAX_ITER: begin
               max_iter_in = csr_write_data[cje_pkg::COUNT_W-1:0];
            end
            default: begin
               max_iter_in = max_iter_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff   <= '0;
         c_imag_ff   <= '0;
         max_iter_ff <= cje_pkg::MAX_ITER_RESET;
      end else begin
         c_real_ff   <= c_real_in;
         c_imag_ff   <= c_imag_in;
         max_iter_ff <= max_iter_in;
      end
   end

   cje_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cje_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .start_real      (req_start_real),
      .start_imag      (req_start_imag),
      .c_real          (c_real_ff),
      .c_imag          (c_imag_ff),
      .max_iterations  (max_iter_ff),
      .iteration_count (rsp_iteration_count)
   );

endmodule

// ===== verif/cubic_julia_escape_time_checker.sv =====
// Checker for the cubic Julia escape-time block: predicts each escape count and compares result beats.
module cubic_julia_escape_time_checker #(
   parameter int FRAC_BITS = cje_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [cje_pkg::VALUE_W-1:0]  req_start_real,
   input  logic signed [cje_pkg::VALUE_W-1:0]  req_start_imag,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [cje_pkg::COUNT_W-1:0]         rsp_iteration_count,
   input  logic                                csr_write_enable,
   input  logic [cje_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cje_pkg::VALUE_W-1:0]         csr_write_data,
   output int                                  pending,
   output int                                  failures
);
   timeunit 1ns;
   timeprecision 1ps;

   // Wide enough for a 32-bit by 33-bit product with room for the sums.
   localparam int ACC_W = 80;

   typedef logic signed [ACC_W-1:0] acc_type;

   // One accepted point and the count it should come back with.
   typedef struct packed {
      logic signed [cje_pkg::VALUE_W-1:0] re;
      logic signed [cje_pkg::VALUE_W-1:0] im;
      logic [cje_pkg::COUNT_W-1:0]        count;
   } point_result_type;

   // Shadow copy of the configuration registers.
   logic signed [cje_pkg::VALUE_W-1:0] c_real_cfg;
   logic signed [cje_pkg::VALUE_W-1:0] c_imag_cfg;
   logic [cje_pkg::COUNT_W-1:0]        limit_cfg;

   point_result_type expected_counts[$];

   // Clamp to the signed range of the given number of bits.
   function automatic acc_type clamp_bits(input acc_type v, input int bits);
      acc_type top;
      top = acc_type'(1) <<< (bits - 1);
      if (v >= top) return top - 1;
      if (v < -top) return -top;
      return v;
   endfunction

   // Iterate z = z^3 + c in fixed point and count the steps taken inside radius two.
   function automatic logic [cje_pkg::COUNT_W-1:0] escape_count(
      input logic signed [cje_pkg::VALUE_W-1:0] start_re,
      input logic signed [cje_pkg::VALUE_W-1:0] start_im,
      input logic signed [cje_pkg::VALUE_W-1:0] c_re,
      input logic signed [cje_pkg::VALUE_W-1:0] c_im,
      input logic [cje_pkg::COUNT_W-1:0]        lim
   );
      acc_type zr;
      acc_type zi;
      acc_type rr;
      acc_type ii;
      acc_type a;
      acc_type b;
      acc_type mag;
      acc_type bailout;
      logic [cje_pkg::COUNT_W-1:0] n;
      zr = start_re;
      zi = start_im;
      n = '0;
      bailout = acc_type'(1) <<< (2 * FRAC_BITS + 2);
      while (n < lim) begin
         mag = zr * zr + zi * zi;
         // When four no longer fits in 64 bits at this scale, nothing escapes.
         if (2 * FRAC_BITS + 2 < 64 && mag >= bailout) break;
         rr = clamp_bits((zr * zr) >>> FRAC_BITS, 32);
         ii = clamp_bits((zi * zi) >>> FRAC_BITS, 32);
         a  = clamp_bits(rr - 3 * ii, 33);
         b  = clamp_bits(3 * rr - ii, 33);
         zr = clamp_bits(((zr * a) >>> FRAC_BITS) + c_re, 32);
         zi = clamp_bits(((zi * b) >>> FRAC_BITS) + c_im, 32);
         n++;
      end
      return n;
   endfunction

   // Print one line for a failure and count it.
   task automatic flag_error(input string line);
      $display("%0t mismatch: %s", $time, line);
      failures++;
   endtask

   // Track configuration, predict on each request beat and check each result beat.
   always @(posedge clock) begin
      point_result_type head;
      if (reset) begin
         c_real_cfg = '0;
         c_imag_cfg = '0;
         limit_cfg = cje_pkg::MAX_ITER_RESET;
         expected_counts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               flag_error($sformatf("result beat with count %0d but no point outstanding",
                                    rsp_iteration_count));
            end else begin
               head = expected_counts.pop_front();
               if (rsp_iteration_count !== head.count) begin
                  flag_error($sformatf("point (%0d, %0d): count %0d, predicted %0d",
                                       head.re, head.im, rsp_iteration_count, head.count));
               end
            end
         end
         if (req_valid && req_ready) begin
            head.re = req_start_real;
            head.im = req_start_imag;
            head.count = escape_count(req_start_real, req_start_imag,
                                      c_real_cfg, c_imag_cfg, limit_cfg);
            expected_counts.push_back(head);
         end
         if (csr_write_enable) begin
            case (csr_index)
               cje_pkg::CSR_C_REAL: begin
                  c_real_cfg = csr_write_data;
               end
               cje_pkg::CSR_C_IMAG: begin
                  c_imag_cfg = csr_write_data;
               end
               cje_pkg::CSR_MAX_ITER: begin
                  limit_cfg = csr_write_data[cje_pkg::COUNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      pending <= expected_counts.size();
   end

endmodule

// ===== verif/cubic_julia_escape_time_test.sv =====
// Testbench top for the cubic Julia escape-time block: clock, reset, stimulus and verdict.
module cubic_julia_escape_time_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = cje_pkg::VALUE_W;
   localparam int CW = cje_pkg::COUNT_W;
   localparam int IW = cje_pkg::CSR_IDX_W;

   // Watchdog bound, well above the length of the worst correct run.
   localparam int RUN_LIMIT = 5_000_000;
   // Longest point at the largest limit, plus a margin.
   localparam int DRAIN_CYCLES = 4 * 1023 + 16;
   localparam int IDLE_PCT = 31;
   localparam logic [IW-1:0] CSR_UNMAPPED = 2'd3;

   // Fixed-point landmarks.
   localparam logic signed [VW-1:0] UNIT        = 32'sh1000_0000;
   localparam logic signed [VW-1:0] MOST_POS    = 32'sh7FFF_FFFF;
   localparam logic signed [VW-1:0] MOST_NEG    = 32'sh8000_0000;
   localparam logic signed [VW-1:0] JUST_INSIDE = 32'sh1FFF_FFFF;
   localparam logic signed [VW-1:0] ON_CIRCLE   = 32'sh2000_0000;
   localparam logic signed [VW-1:0] ROOT_TWO    = 32'sh16A0_9E66;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [VW-1:0] req_start_real = '0;
   logic signed [VW-1:0] req_start_imag = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CW-1:0]        rsp_iteration_count;
   logic                 csr_write_enable = 1'b0;
   logic [IW-1:0]        csr_index = '0;
   logic [VW-1:0]        csr_write_data = '0;
   logic                 steady = 1'b0;
   int                   pending;
   int                   failures;
   int                   cycle_count = 0;

   cubic_julia_escape_time u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_real      (req_start_real),
      .req_start_imag      (req_start_imag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   cubic_julia_escape_time_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_real      (req_start_real),
      .req_start_imag      (req_start_imag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .pending             (pending),
      .failures            (failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The result side stalls at random except during the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Uniform value in [-span, span].
   function automatic logic signed [VW-1:0] spread(input int unsigned span);
      return VW'($urandom_range(2 * span) - span);
   endfunction

   // Present one point, with a random gap first, and hold it until its beat is taken.
   task automatic send_point(input logic signed [VW-1:0] zr,
                             input logic signed [VW-1:0] zi);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_real <= zr;
      req_start_imag <= zi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding count to come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IW-1:0] idx, input logic [VW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   // Load c and the limit; junk in the upper limit bits and a write to the spare index.
   task automatic configure(input logic signed [VW-1:0] cr,
                            input logic signed [VW-1:0] ci,
                            input logic [CW-1:0] lim);
      write_reg(cje_pkg::CSR_C_REAL, cr);
      write_reg(cje_pkg::CSR_C_IMAG, ci);
      write_reg(cje_pkg::CSR_MAX_ITER, ($urandom & ~32'h3FF) | VW'(lim));
      write_reg(CSR_UNMAPPED, $urandom);
      csr_write_enable <= 1'b0;
   endtask

   // Random points: full range, within [-2, 2], near the unit and escape radii, and tiny.
   task automatic run_random(input int n);
      int pick;
      logic signed [VW-1:0] zr;
      logic signed [VW-1:0] zi;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            zr = $urandom;
            zi = $urandom;
         end else if (pick < 70) begin
            zr = spread(ON_CIRCLE);
            zi = spread(ON_CIRCLE);
         end else if (pick < 85) begin
            zr = $urandom_range(1) ? UNIT : JUST_INSIDE;
            if ($urandom_range(1)) zr = -zr;
            zr = zr + spread(4096);
            zi = spread(4096);
            if ($urandom_range(1)) {zr, zi} = {zi, zr};
         end else begin
            zr = spread(1 << 19);
            zi = spread(1 << 19);
         end
         send_point(zr, zi);
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: extremes, the bailout edge, fixed points at +-1, and +-i.
      send_point('0, '0);
      send_point(MOST_POS, MOST_POS);
      send_point(MOST_NEG, MOST_NEG);
      send_point(MOST_POS, MOST_NEG);
      send_point(MOST_NEG, MOST_POS);
      send_point(JUST_INSIDE, '0);
      send_point(ON_CIRCLE, '0);
      send_point('0, -JUST_INSIDE);
      send_point(UNIT, '0);
      send_point(-UNIT, '0);
      send_point('0, UNIT);
      send_point('0, -UNIT);
      send_point(32'sd1, -32'sd1);
      send_point(-32'sd1, 32'sd1);
      send_point(UNIT >>> 1, UNIT >>> 1);
      send_point(ROOT_TWO, ROOT_TWO);
      drain();

      // A zero limit returns zero for any point.
      configure('0, '0, 10'd0);
      send_point('0, '0);
      send_point(MOST_NEG, MOST_POS);
      drain();

      // Largest limit on points that never leave.
      configure('0, '0, 10'd1023);
      send_point('0, '0);
      send_point(UNIT, '0);
      drain();

      // Extreme c drives z into saturation after the first step.
      configure(MOST_POS, MOST_NEG, 10'd50);
      send_point('0, '0);
      send_point(UNIT, UNIT);
      drain();

      configure('0, '0, 10'd100);
      run_random(250);
      drain();

      configure(spread(UNIT), spread(UNIT), 10'd60);
      run_random(300);
      drain();

      configure(spread(UNIT >>> 1), spread(UNIT >>> 1), 10'd1023);
      run_random(60);
      drain();

      configure(MOST_POS, MOST_NEG, 10'd50);
      run_random(150);
      drain();

      configure(spread(ON_CIRCLE), spread(ON_CIRCLE), 10'd1);
      run_random(200);
      drain();

      configure($urandom, $urandom, 10'd0);
      run_random(40);
      drain();

      configure(spread(UNIT), spread(UNIT), 10'd200);
      run_random(300);
      drain();

      // Back-to-back stretch with neither side idling.
      steady <= 1'b1;
      configure(spread(UNIT), spread(UNIT), 10'd20);
      run_random(350);
      drain();
      steady <= 1'b0;

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
